// File: hdl/mmss_pkg.sv
// shared types, constants and glyph tables for the seven segment scanner
// no dependencies; imported by every module of the block
`default_nettype none

package mmss_pkg;

  // channel and register widths
  localparam int OP_W       = 2;
  localparam int SAMPLE_W   = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int SEG_W      = 8;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int FS_W       = 14;
  localparam int MV_W       = 14;
  localparam int FRAC_W     = 10;
  localparam int BCD_W      = 4;
  localparam int DIGITS     = 4;
  localparam int DIG_W      = 2;

  // configuration map, register index taken from paddr[2]
  localparam logic CFG_IDX_FS = 1'b0;
  localparam logic [FS_W-1:0] FS_RESET = 14'd3300;

  localparam int ADC_BITS_DEF = 12;

  // product of sample and full scale
  localparam int PROD_W = SAMPLE_W + FS_W;
  // reciprocal of 2^adc_bits-1 scaled by 2^(prod_w+adc_bits) fits in one more bit
  localparam int RECIP_W = PROD_W + 1;

  localparam logic [MV_W-1:0] MV_MAX = 14'd9999;

  // constant dividers for decimal digits
  localparam int PR3_W      = 27;
  localparam int THOU_RECIP = 8389;
  localparam int THOU_SH    = 23;
  localparam int THOU       = 1000;
  localparam int TEN_PW     = 18;
  localparam int TEN_RECIP  = 205;
  localparam int TEN_SH     = 11;
  localparam int HUND_PW    = 16;
  localparam int HUND_RECIP = 41;
  localparam int HUND_SH    = 12;
  localparam int Q10_W      = 7;

  // clock digits in scan order
  localparam logic [DIG_W-1:0] DIG_M10 = 2'd0;
  localparam logic [DIG_W-1:0] DIG_M1  = 2'd1;
  localparam logic [DIG_W-1:0] DIG_S10 = 2'd2;
  localparam logic [DIG_W-1:0] DIG_S1  = 2'd3;

  localparam logic [SEG_W-1:0] SEG_POINT_MASK = 8'h7F;
  localparam logic [SEG_W-1:0] SEG_ALL_MASK   = 8'hFF;
  localparam logic [SEG_W-1:0] SEL_BASE       = 8'hF0;

  typedef enum logic [OP_W-1:0] {
    OP_POLL    = 2'd0,
    OP_SECOND  = 2'd1,
    OP_REFRESH = 2'd2,
    OP_SPARE   = 2'd3
  } mmss_op_t;

  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic             volt_view;
    logic [BCD_W-1:0] clk_bcd;
  } mmss_tok_t;

  typedef struct packed {
    mmss_tok_t            tok;
    logic [SAMPLE_W-1:0]  sample;
  } mmss_req_t;

  typedef struct packed {
    mmss_tok_t           tok;
    logic [BCD_W-1:0]    thou;
    logic [FRAC_W-1:0]   frac;
    logic [Q10_W-1:0]    q10;
    logic [BCD_W-1:0]    q100;
  } mmss_vres_t;

  // active-low glyphs, segments a..g in bits 0..6
  function automatic logic [SEG_W-1:0] glyph(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] g;
    unique case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = 8'hFF;
    endcase
    return g;
  endfunction

  function automatic logic [SEG_W-1:0] digit_select(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    s = SEL_BASE | (SEG_W'(1) << d);
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mmss_ctrl.sv
// input register, seconds counter, reset button edge and digit scan state
// depends on mmss_pkg
`default_nettype none

module mmss_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mmss_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [mmss_pkg::OP_W-1:0]      in_tuser,
  output logic                           req_valid,
  input  logic                           req_ready,
  output mmss_pkg::mmss_req_t            req
);
  import mmss_pkg::*;

  logic                               a_vld_r;
  mmss_op_t                           op_r;
  logic                               rstb_r;
  logic                               mode_r;
  logic [SAMPLE_W-1:0]                smp_r;

  logic                               last_r, last_nxt;
  logic [DIG_W-1:0]                   digit_r, digit_nxt;
  logic [DIGITS-1:0][BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [DIGITS-1:0][BCD_W-1:0]       cur;
  logic                               fall;
  logic                               a_fire;

  assign a_fire    = a_vld_r && ((op_r != OP_REFRESH) || req_ready);
  assign in_tready = !a_vld_r || a_fire;
  assign req_valid = a_vld_r && (op_r == OP_REFRESH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_tready) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= mmss_op_t'(in_tuser);
      rstb_r <= in_tdata[0];
      mode_r <= in_tdata[1];
      smp_r  <= in_tdata[2 +: SAMPLE_W];
    end
  end

  // count held as four decimal digits, 99:59 wraps to 00:00
  always_comb begin
    fall      = !rstb_r && last_r;
    cur       = fall ? '0 : bcd_r;
    bcd_nxt   = bcd_r;
    last_nxt  = last_r;
    digit_nxt = digit_r;
    if (a_fire) begin
      bcd_nxt  = cur;
      last_nxt = rstb_r;
      unique case (op_r)
        OP_SECOND: begin
          if (cur[DIG_S1] == 4'd9) begin
            bcd_nxt[DIG_S1] = '0;
            if (cur[DIG_S10] == 4'd5) begin
              bcd_nxt[DIG_S10] = '0;
              if (cur[DIG_M1] == 4'd9) begin
                bcd_nxt[DIG_M1]  = '0;
                bcd_nxt[DIG_M10] = (cur[DIG_M10] == 4'd9) ? '0 : cur[DIG_M10] + 4'd1;
              end else begin
                bcd_nxt[DIG_M1] = cur[DIG_M1] + 4'd1;
              end
            end else begin
              bcd_nxt[DIG_S10] = cur[DIG_S10] + 4'd1;
            end
          end else begin
            bcd_nxt[DIG_S1] = cur[DIG_S1] + 4'd1;
          end
        end
        OP_REFRESH: begin
          digit_nxt = digit_r + 2'd1;
        end
        OP_POLL, OP_SPARE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= 1'b1;
      digit_r <= '0;
      bcd_r   <= '0;
    end else begin
      last_r  <= last_nxt;
      digit_r <= digit_nxt;
      bcd_r   <= bcd_nxt;
    end
  end

  always_comb begin
    req.tok.digit     = digit_r;
    req.tok.volt_view = !mode_r;
    req.tok.clk_bcd   = cur[digit_r];
    req.sample        = smp_r;
  end

endmodule

`default_nettype wire

// File: hdl/mmss_volt.sv
// millivolt pipeline: scale the sample, divide by full-scale code,
// saturate and split into decimal parts; depends on mmss_pkg
`default_nettype none

module mmss_volt #(
  parameter int ADC_BITS = mmss_pkg::ADC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mmss_pkg::FS_W-1:0] fs_mv,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  mmss_pkg::mmss_req_t       req,
  output logic                      vres_valid,
  input  logic                      vres_ready,
  output mmss_pkg::mmss_vres_t      vres
);
  import mmss_pkg::*;

  localparam int NSTG = 6;
  localparam int S    = PROD_W + ADC_BITS;
  localparam int MW   = PROD_W + RECIP_W;
  localparam int QW   = MW - S;
  localparam int RW   = PROD_W + 1;
  localparam int CW   = (QW + 1 > MV_W) ? QW + 1 : MV_W;
  localparam logic [63:0] DIV64 = (64'd1 << ADC_BITS) - 64'd1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << S) / DIV64);
  localparam logic [RW-1:0] DIV = RW'(DIV64);

  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   rdy;
  mmss_tok_t       tok_r [NSTG];

  logic [PROD_W-1:0]  p0_r, p1_r;
  logic [MW-1:0]      m1_r;
  logic [MV_W-1:0]    mv2_r, mv3_r;
  logic [PR3_W-1:0]   pr3_r;
  logic [BCD_W-1:0]   th4_r, th5_r;
  logic [FRAC_W-1:0]  frac4_r, frac5_r;
  logic [Q10_W-1:0]   q10_r;
  logic [BCD_W-1:0]   q100_r;

  logic [QW-1:0]      q_est;
  logic [RW-1:0]      rem;
  logic [CW-1:0]      q_ext;
  logic [MV_W-1:0]    mv2_nxt;
  logic [BCD_W-1:0]   th4_nxt;
  logic [FRAC_W-1:0]  frac4_nxt;
  logic [TEN_PW-1:0]  ten_p;
  logic [HUND_PW-1:0] hund_p;

  always_comb begin
    rdy[NSTG] = vres_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign req_ready  = rdy[0];
  assign vres_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= (i == 0) ? req_valid : vld_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        tok_r[i] <= (i == 0) ? req.tok : tok_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // estimate is exact or one short; remainder check fixes it
  always_comb begin
    q_est   = m1_r[MW-1:S];
    rem     = RW'(p1_r) + RW'(q_est) - (RW'(q_est) << ADC_BITS);
    q_ext   = CW'(q_est) + CW'(rem >= DIV);
    mv2_nxt = (q_ext > CW'(MV_MAX)) ? MV_MAX : MV_W'(q_ext);
    th4_nxt   = pr3_r[PR3_W-1:THOU_SH];
    frac4_nxt = FRAC_W'(mv3_r - MV_W'(th4_nxt) * MV_W'(THOU));
    ten_p     = TEN_PW'(frac4_r) * TEN_PW'(TEN_RECIP);
    hund_p    = HUND_PW'(frac4_r) * HUND_PW'(HUND_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p0_r <= PROD_W'(req.sample) * PROD_W'(fs_mv);
    end
    if (rdy[1]) begin
      p1_r <= p0_r;
      m1_r <= MW'(p0_r) * MW'(RECIP);
    end
    if (rdy[2]) begin
      mv2_r <= mv2_nxt;
    end
    if (rdy[3]) begin
      mv3_r <= mv2_r;
      pr3_r <= PR3_W'(mv2_r) * PR3_W'(THOU_RECIP);
    end
    if (rdy[4]) begin
      th4_r   <= th4_nxt;
      frac4_r <= frac4_nxt;
    end
    if (rdy[5]) begin
      th5_r   <= th4_r;
      frac5_r <= frac4_r;
      q10_r   <= Q10_W'(ten_p >> TEN_SH);
      q100_r  <= BCD_W'(hund_p >> HUND_SH);
    end
  end

  always_comb begin
    vres.tok  = tok_r[NSTG-1];
    vres.thou = th5_r;
    vres.frac = frac5_r;
    vres.q10  = q10_r;
    vres.q100 = q100_r;
  end

endmodule

`default_nettype wire

// File: hdl/mmss_out.sv
// digit selection, glyph lookup and result register
// depends on mmss_pkg
`default_nettype none

module mmss_out (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            vres_valid,
  output logic                            vres_ready,
  input  mmss_pkg::mmss_vres_t            vres,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mmss_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mmss_pkg::*;

  logic               ovld_r;
  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic [SEG_W-1:0]   sel_r;
  logic [FRAC_W-1:0]  ones_w;
  logic [Q10_W-1:0]   tens_w;
  logic [BCD_W-1:0]   bcd;
  logic               point;

  assign vres_ready = !ovld_r || out_tready;

  always_comb begin
    ones_w = vres.frac - FRAC_W'(vres.q10) * FRAC_W'(10);
    tens_w = vres.q10 - Q10_W'(vres.q100) * Q10_W'(10);
    if (vres.tok.volt_view) begin
      unique case (vres.tok.digit)
        2'd0:    bcd = vres.thou;
        2'd1:    bcd = vres.q100;
        2'd2:    bcd = tens_w[BCD_W-1:0];
        default: bcd = ones_w[BCD_W-1:0];
      endcase
      point = (vres.tok.digit == 2'd0);
    end else begin
      bcd   = vres.tok.clk_bcd;
      point = (vres.tok.digit == DIG_M1);
    end
    seg_nxt = glyph(bcd) & (point ? SEG_POINT_MASK : SEG_ALL_MASK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (vres_ready) begin
      ovld_r <= vres_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (vres_ready && vres_valid) begin
      seg_r <= seg_nxt;
      sel_r <= digit_select(vres.tok.digit);
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {sel_r, seg_r};

endmodule

`default_nettype wire

// File: hdl/mmss_voltage_seven_segment_scanner.sv
// top level of the four digit clock / voltage scanner
// depends on mmss_pkg, mmss_ctrl, mmss_volt, mmss_out
`default_nettype none

// Input words are taken in one per clock while no refresh word waits in the input
// register for a stalled datapath. Button levels and ticks act on the seconds
// count and scan digit as the word leaves the input register, so a word that
// yields no result (poll, second tick, spare code) produces nothing. A refresh
// tick yields one segment/select word after passing the input register, six
// stages of the millivolt datapath (sample times full scale, reciprocal multiply
// for the full-scale code, correction and saturation at 9999, then decimal
// split) and the result register. The datapath is fully pipelined, so refresh
// ticks also sustain one per clock; a stalled output only holds words back once
// the pipeline fills. full_scale_millivolts lies at byte address 0 and resets
// to 3300; write it only while no word is in flight.

module mmss_voltage_seven_segment_scanner #(
  parameter int ADC_BITS = mmss_pkg::ADC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // reset_button[0], mode_button[1], pot_sample[13:2], zero[15:14]
  input  logic [mmss_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [mmss_pkg::OP_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // segment_byte[7:0], select_byte[15:8]
  output logic [mmss_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mmss_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [mmss_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [mmss_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import mmss_pkg::*;

  logic [FS_W-1:0] fs_r;
  logic            req_valid, req_ready;
  mmss_req_t       req;
  logic            vres_valid, vres_ready;
  mmss_vres_t      vres;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == CFG_IDX_FS)) begin
      fs_r <= cfg_pwdata[FS_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_FS) ? CFG_DW'(fs_r) : '0;

  mmss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  mmss_volt #(
    .ADC_BITS (ADC_BITS)
  ) u_volt (
    .clk        (clk),
    .rst_n      (rst_n),
    .fs_mv      (fs_r),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .vres_valid (vres_valid),
    .vres_ready (vres_ready),
    .vres       (vres)
  );

  mmss_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .vres_valid (vres_valid),
    .vres_ready (vres_ready),
    .vres       (vres),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: hdl/mmss_chk.sv
// port-level checks on the result channel of the scanner
// depends on mmss_pkg; bound to mmss_voltage_seven_segment_scanner
`default_nettype none

module mmss_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mmss_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mmss_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // select byte lights exactly one digit
  a_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:12] == 4'hF) && $onehot(out_tdata[11:8]))
    else $error("bad digit select byte");

  // point or colon only on the first two digits
  a_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[7] |-> (out_tdata[15:8] == 8'hF1) ||
                                     (out_tdata[15:8] == 8'hF2))
    else $error("point lit on wrong digit");

  // nothing leaves right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind mmss_voltage_seven_segment_scanner mmss_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
